// File: hdl/sfpd_pkg.sv
package sfpd_pkg;

   localparam int DEF_WINDOW_LEN  = 8;
   localparam int DEF_FRONT_LEN   = 4;
   localparam int DEF_HISTORY_LEN = 8;

   localparam int SAMPLE_W    = 16;
   localparam int DIFF_W      = 17;
   localparam int CFG_W       = 16;
   localparam int PEAK_INT_W  = 22;
   localparam int RSP_DATA_W  = 24;
   localparam int FLEN_W      = 8;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;

   localparam logic signed [FLEN_W-1:0] FLEN_MAX = 8'sd127;
   localparam logic signed [FLEN_W-1:0] FLEN_MIN = -8'sd127;

   localparam logic [CFG_W-1:0] MIN_SLOPE_RST = 16'd10;
   localparam logic [CFG_W-1:0] RATIO_RST     = 16'd256;

   localparam logic REG_MIN_SLOPE = 1'b0;
   localparam logic REG_RATIO     = 1'b1;

   typedef logic signed [DIFF_W-1:0] sfpd_diff_type;

   typedef struct packed {
      logic full;
      logic empty;
   } sfpd_qstat_type;

endpackage

// File: hdl/slope_front_peak_detector_top.sv
// Slope front peak detector. Each req transfer carries one signed sample and
// produces exactly one rsp transfer; peak is set when that sample completes a
// detected peak, and peak_intensity then holds the recorded front intensity.
// Samples enter a four-entry queue as differences and are worked off one at a
// time by a sequencer that keeps the running slope and intensity sums: a
// warm-up sample only fills the window, a regular sample passes the slope,
// intensity, tracking and decision states (plus a ratio multiply and compare
// on a long rising front), and a peak sample adds a bit-serial division for
// the new history mean. min_slope lies at byte address 0 and ratio_q8 (Q8.8)
// at byte address 4; write them only while no sample is in flight.
module slope_front_peak_detector_top import sfpd_pkg::*; #(
   parameter int WINDOW_LEN  = DEF_WINDOW_LEN,
   parameter int FRONT_LEN   = DEF_FRONT_LEN,
   parameter int HISTORY_LEN = DEF_HISTORY_LEN
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [SAMPLE_W-1:0]   req_tdata,    // [15:0] sample
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,    // [21:0] peak_intensity, [23:22] zero
   output logic [0:0]            rsp_tuser,    // [0] peak
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [CFG_W-1:0]      min_slope_ff, min_slope_in;
   logic [CFG_W-1:0]      ratio_ff, ratio_in;
   logic                  csr_wr;
   sfpd_qstat_type        qstat;
   logic                  push, pop;
   sfpd_diff_type         push_data, pop_data;
   logic                  rsp_peak;
   logic [PEAK_INT_W-1:0] rsp_int;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = CSR_DATA_W'((csr_paddr[2] == REG_RATIO) ? ratio_ff : min_slope_ff);

   always_comb begin
      min_slope_in = min_slope_ff;
      ratio_in     = ratio_ff;
      if (csr_wr) begin
         if (csr_paddr[2] == REG_MIN_SLOPE) begin
            min_slope_in = csr_pwdata[CFG_W-1:0];
         end else begin
            ratio_in = csr_pwdata[CFG_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_slope_ff <= MIN_SLOPE_RST;
         ratio_ff     <= RATIO_RST;
      end else begin
         min_slope_ff <= min_slope_in;
         ratio_ff     <= ratio_in;
      end
   end

   sfpd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .qstat      (qstat),
      .push       (push),
      .push_data  (push_data)
   );

   sfpd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .stat      (qstat)
   );

   sfpd_back #(
      .WINDOW_LEN  (WINDOW_LEN),
      .FRONT_LEN   (FRONT_LEN),
      .HISTORY_LEN (HISTORY_LEN)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .qstat              (qstat),
      .pop_data           (pop_data),
      .pop                (pop),
      .min_slope          (min_slope_ff),
      .ratio_q8           (ratio_ff),
      .rsp_valid          (rsp_tvalid),
      .rsp_ready          (rsp_tready),
      .rsp_peak           (rsp_peak),
      .rsp_peak_intensity (rsp_int)
   );

   assign rsp_tdata = RSP_DATA_W'(rsp_int);
   assign rsp_tuser = rsp_peak;

endmodule

// File: hdl/sfpd_queue.sv
module sfpd_queue import sfpd_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  sfpd_diff_type  push_data,
   input  logic           pop,
   output sfpd_diff_type  pop_data,
   output sfpd_qstat_type stat
);

   sfpd_diff_type     entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data   = entry_ff[rd_ptr_ff];
   assign stat.full  = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign stat.empty = (count_ff == '0);

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      stat.full |-> !push) else $error("Queue written while full.");

endmodule

// File: hdl/sfpd_front.sv
module sfpd_front import sfpd_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [SAMPLE_W-1:0] req_tdata,
   input  sfpd_qstat_type      qstat,
   output logic                push,
   output sfpd_diff_type       push_data
);

   logic signed [SAMPLE_W-1:0] prev_ff, prev_in;
   logic signed [SAMPLE_W-1:0] sample;

   assign sample     = $signed(req_tdata);
   assign req_tready = !qstat.full;
   assign push       = req_tvalid && req_tready;
   assign push_data  = DIFF_W'(sample) - DIFF_W'(prev_ff);

   always_comb begin
      prev_in = prev_ff;
      if (push) begin
         prev_in = sample;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
      end else begin
         prev_ff <= prev_in;
      end
   end

endmodule

// File: hdl/sfpd_back.sv
module sfpd_back import sfpd_pkg::*; #(
   parameter int WINDOW_LEN  = DEF_WINDOW_LEN,
   parameter int FRONT_LEN   = DEF_FRONT_LEN,
   parameter int HISTORY_LEN = DEF_HISTORY_LEN
) (
   input  logic                  clock,
   input  logic                  reset,
   input  sfpd_qstat_type        qstat,
   input  sfpd_diff_type         pop_data,
   output logic                  pop,
   input  logic [CFG_W-1:0]      min_slope,
   input  logic [CFG_W-1:0]      ratio_q8,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_peak,
   output logic [PEAK_INT_W-1:0] rsp_peak_intensity
);

   localparam int DPTR_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
   localparam int WCNT_W = $clog2(WINDOW_LEN + 1);
   localparam int SPTR_W = (FRONT_LEN > 1) ? $clog2(FRONT_LEN) : 1;
   localparam int HPTR_W = (HISTORY_LEN > 1) ? $clog2(HISTORY_LEN) : 1;
   localparam int HCNT_W = $clog2(HISTORY_LEN + 1);
   localparam int SLOPE_W = DIFF_W + $clog2(WINDOW_LEN);
   localparam int INT_W   = SLOPE_W + $clog2(FRONT_LEN);
   localparam int MAXI_W  = INT_W - 1;
   localparam int HSUM_W  = MAXI_W + $clog2(HISTORY_LEN);
   localparam int DCNT_W  = $clog2(HSUM_W + 1);
   localparam int PROD_W  = MAXI_W + CFG_W;
   localparam int EXT_W   = (MAXI_W > PEAK_INT_W) ? MAXI_W : PEAK_INT_W;
   localparam logic signed [FLEN_W-1:0] FRONT_POS = FLEN_W'(FRONT_LEN);
   localparam logic signed [FLEN_W-1:0] FRONT_NEG = -FRONT_POS;

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_SLOPE  = 4'd1;
   localparam logic [3:0] ST_INTEN  = 4'd2;
   localparam logic [3:0] ST_TRACK  = 4'd3;
   localparam logic [3:0] ST_DECIDE = 4'd4;
   localparam logic [3:0] ST_MUL    = 4'd5;
   localparam logic [3:0] ST_CMP    = 4'd6;
   localparam logic [3:0] ST_DIVI   = 4'd7;
   localparam logic [3:0] ST_DIV    = 4'd8;
   localparam logic [3:0] ST_OUT    = 4'd9;

   logic [3:0] state_ff, state_in;

   sfpd_diff_type             diff_mem [WINDOW_LEN];
   logic signed [SLOPE_W-1:0] slope_mem [FRONT_LEN];
   logic [MAXI_W-1:0]         hist_mem [HISTORY_LEN];

   sfpd_diff_type             diff_rd_ff;
   logic signed [SLOPE_W-1:0] slope_rd_ff;
   logic [MAXI_W-1:0]         hist_rd_ff;

   logic                      dmem_we, smem_we, hmem_we;
   sfpd_diff_type             dmem_wdata;

   logic [WCNT_W-1:0]         warm_ff, warm_in;
   logic [DPTR_W-1:0]         dptr_ff, dptr_in, dptr_next;
   logic signed [SLOPE_W-1:0] dsum_ff, dsum_in;
   sfpd_diff_type             diff_ff, diff_in;
   logic signed [SLOPE_W-1:0] slope_ff, slope_in, slope_new;
   logic [SPTR_W-1:0]         sptr_ff, sptr_in, sptr_next;
   logic [FRONT_LEN-1:0]      svalid_ff, svalid_in;
   logic signed [INT_W-1:0]   isum_ff, isum_in, inten_new;
   logic signed [INT_W-1:0]   inten_ff, inten_in;
   logic signed [SLOPE_W-1:0] old_slope;
   logic signed [FLEN_W-1:0]  flen_ff, flen_in;
   logic [MAXI_W-1:0]         max_ff, max_in;
   logic                      rose_ff, rose_in;
   logic [HPTR_W-1:0]         hptr_ff, hptr_in, hptr_next;
   logic [HISTORY_LEN-1:0]    hvalid_ff, hvalid_in;
   logic [HSUM_W-1:0]         hsum_ff, hsum_in;
   logic [HCNT_W-1:0]         hcnt_ff, hcnt_in;
   logic [MAXI_W-1:0]         mean_ff, mean_in;
   logic [PROD_W-1:0]         prod_ff, prod_in;
   logic [HSUM_W-1:0]         dvd_ff, dvd_in;
   logic [HCNT_W-1:0]         rem_ff, rem_in;
   logic [DCNT_W-1:0]         dcnt_ff, dcnt_in;
   logic                      res_peak_ff, res_peak_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_peak_ff, rsp_peak_in;
   logic [PEAK_INT_W-1:0]     rsp_int_ff, rsp_int_in;

   logic [SLOPE_W-1:0]        slope_mag;
   logic                      slope_neg, slope_pos, slope_small;
   logic                      flen_neg, flen_pos;
   logic                      peak_cond, old_pos, new_pos;
   logic [HCNT_W:0]           trial, trial_sub;
   logic                      trial_ge;
   logic [EXT_W-1:0]          max_ext;

   assign dptr_next = (dptr_ff == DPTR_W'(WINDOW_LEN - 1)) ? '0 : dptr_ff + 1'b1;
   assign sptr_next = (sptr_ff == SPTR_W'(FRONT_LEN - 1)) ? '0 : sptr_ff + 1'b1;
   assign hptr_next = (hptr_ff == HPTR_W'(HISTORY_LEN - 1)) ? '0 : hptr_ff + 1'b1;

   assign slope_new = dsum_ff - SLOPE_W'(diff_rd_ff) + SLOPE_W'(diff_ff);
   assign old_slope = svalid_ff[sptr_ff] ? slope_rd_ff : '0;
   assign inten_new = isum_ff - INT_W'(old_slope) + INT_W'(slope_ff);

   assign slope_neg   = slope_ff[SLOPE_W-1];
   assign slope_pos   = !slope_neg && (slope_ff != '0);
   assign slope_mag   = slope_neg ? SLOPE_W'(-slope_ff) : SLOPE_W'(slope_ff);
   assign slope_small = slope_mag < SLOPE_W'(min_slope);
   assign flen_neg    = flen_ff[FLEN_W-1];
   assign flen_pos    = !flen_neg && (flen_ff != '0);

   assign peak_cond = rose_ff && (flen_ff <= FRONT_NEG);
   assign old_pos   = hvalid_ff[hptr_ff] && (hist_rd_ff != '0);
   assign new_pos   = (max_ff != '0);

   assign trial     = {rem_ff, dvd_ff[HSUM_W-1]};
   assign trial_ge  = trial >= {1'b0, hcnt_ff};
   assign trial_sub = trial - {1'b0, hcnt_ff};
   assign max_ext   = EXT_W'(max_ff);

   always_comb begin
      state_in     = state_ff;
      pop          = 1'b0;
      dmem_we      = 1'b0;
      smem_we      = 1'b0;
      hmem_we      = 1'b0;
      dmem_wdata   = diff_ff;
      warm_in      = warm_ff;
      dptr_in      = dptr_ff;
      dsum_in      = dsum_ff;
      diff_in      = diff_ff;
      slope_in     = slope_ff;
      sptr_in      = sptr_ff;
      svalid_in    = svalid_ff;
      isum_in      = isum_ff;
      inten_in     = inten_ff;
      flen_in      = flen_ff;
      max_in       = max_ff;
      rose_in      = rose_ff;
      hptr_in      = hptr_ff;
      hvalid_in    = hvalid_ff;
      hsum_in      = hsum_ff;
      hcnt_in      = hcnt_ff;
      mean_in      = mean_ff;
      prod_in      = prod_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      dcnt_in      = dcnt_ff;
      res_peak_in  = res_peak_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_peak_in  = rsp_peak_ff;
      rsp_int_in   = rsp_int_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (!qstat.empty) begin
               pop     = 1'b1;
               diff_in = pop_data;
               if (warm_ff < WCNT_W'(WINDOW_LEN)) begin
                  dmem_we     = 1'b1;
                  dmem_wdata  = pop_data;
                  dsum_in     = dsum_ff + SLOPE_W'(pop_data);
                  warm_in     = warm_ff + 1'b1;
                  dptr_in     = dptr_next;
                  res_peak_in = 1'b0;
                  state_in    = ST_OUT;
               end else begin
                  state_in = ST_SLOPE;
               end
            end
         end
         ST_SLOPE: begin
            dmem_we  = 1'b1;
            dsum_in  = slope_new;
            slope_in = slope_new;
            dptr_in  = dptr_next;
            state_in = ST_INTEN;
         end
         ST_INTEN: begin
            smem_we            = 1'b1;
            svalid_in[sptr_ff] = 1'b1;
            isum_in            = inten_new;
            inten_in           = inten_new;
            sptr_in            = sptr_next;
            state_in           = ST_TRACK;
         end
         ST_TRACK: begin
            if (!slope_small) begin
               if ((slope_pos && flen_neg) || (slope_neg && flen_pos)) begin
                  flen_in = '0;
                  if (!rose_ff) begin
                     max_in = '0;
                  end
               end else if (slope_pos) begin
                  if (flen_ff < FLEN_MAX) begin
                     flen_in = flen_ff + 8'sd1;
                  end
                  if (inten_ff > $signed({1'b0, max_ff})) begin
                     max_in = inten_ff[MAXI_W-1:0];
                  end
               end else if (slope_neg) begin
                  if (flen_ff > FLEN_MIN) begin
                     flen_in = flen_ff - 8'sd1;
                  end
               end
            end
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            res_peak_in = 1'b0;
            if (peak_cond) begin
               hmem_we            = 1'b1;
               hvalid_in[hptr_ff] = 1'b1;
               hsum_in            = hsum_ff - (hvalid_ff[hptr_ff] ? HSUM_W'(hist_rd_ff) : '0)
                                    + HSUM_W'(max_ff);
               hcnt_in            = hcnt_ff - HCNT_W'(old_pos) + HCNT_W'(new_pos);
               hptr_in            = hptr_next;
               dsum_in            = '0;
               warm_in            = '0;
               dptr_in            = '0;
               svalid_in          = '0;
               isum_in            = '0;
               rose_in            = 1'b0;
               res_peak_in        = 1'b1;
               state_in           = ST_DIVI;
            end else if (flen_ff >= FRONT_POS) begin
               state_in = ST_MUL;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_MUL: begin
            prod_in  = PROD_W'(mean_ff) * PROD_W'(ratio_q8);
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (PROD_W'({max_ff, 8'd0}) > prod_ff) begin
               rose_in = 1'b1;
            end
            state_in = ST_OUT;
         end
         ST_DIVI: begin
            dvd_in   = hsum_ff;
            rem_in   = '0;
            dcnt_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in  = trial_ge ? trial_sub[HCNT_W-1:0] : trial[HCNT_W-1:0];
            dvd_in  = {dvd_ff[HSUM_W-2:0], trial_ge};
            dcnt_in = dcnt_ff + 1'b1;
            if (dcnt_ff == DCNT_W'(HSUM_W - 1)) begin
               mean_in  = (hcnt_ff == '0) ? '0 : dvd_in[MAXI_W-1:0];
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_peak_in  = res_peak_ff;
               rsp_int_in   = res_peak_ff ? max_ext[PEAK_INT_W-1:0] : '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         warm_ff      <= '0;
         dptr_ff      <= '0;
         dsum_ff      <= '0;
         sptr_ff      <= '0;
         svalid_ff    <= '0;
         isum_ff      <= '0;
         flen_ff      <= '0;
         max_ff       <= '0;
         rose_ff      <= 1'b0;
         hptr_ff      <= '0;
         hvalid_ff    <= '0;
         hsum_ff      <= '0;
         hcnt_ff      <= '0;
         mean_ff      <= '0;
         res_peak_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         warm_ff      <= warm_in;
         dptr_ff      <= dptr_in;
         dsum_ff      <= dsum_in;
         sptr_ff      <= sptr_in;
         svalid_ff    <= svalid_in;
         isum_ff      <= isum_in;
         flen_ff      <= flen_in;
         max_ff       <= max_in;
         rose_ff      <= rose_in;
         hptr_ff      <= hptr_in;
         hvalid_ff    <= hvalid_in;
         hsum_ff      <= hsum_in;
         hcnt_ff      <= hcnt_in;
         mean_ff      <= mean_in;
         res_peak_ff  <= res_peak_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      diff_ff     <= diff_in;
      slope_ff    <= slope_in;
      inten_ff    <= inten_in;
      prod_ff     <= prod_in;
      dvd_ff      <= dvd_in;
      rem_ff      <= rem_in;
      dcnt_ff     <= dcnt_in;
      rsp_peak_ff <= rsp_peak_in;
      rsp_int_ff  <= rsp_int_in;
   end

   always_ff @(posedge clock) begin
      if (dmem_we) begin
         diff_mem[dptr_ff] <= dmem_wdata;
      end
      diff_rd_ff <= diff_mem[dptr_ff];
   end

   always_ff @(posedge clock) begin
      if (smem_we) begin
         slope_mem[sptr_ff] <= slope_ff;
      end
      slope_rd_ff <= slope_mem[sptr_ff];
   end

   always_ff @(posedge clock) begin
      if (hmem_we) begin
         hist_mem[hptr_ff] <= max_ff;
      end
      hist_rd_ff <= hist_mem[hptr_ff];
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_peak           = rsp_peak_ff;
   assign rsp_peak_intensity = rsp_int_ff;

   a_rose_has_max: assert property (@(posedge clock) disable iff (reset)
      rose_ff |-> (max_ff != '0)) else $error("Armed front without a peak intensity.");

   a_peak_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECIDE) && peak_cond |=> (warm_ff == '0) && (isum_ff == '0) && !rose_ff)
      else $error("Peak did not clear the windows.");

   a_hcnt_range: assert property (@(posedge clock) disable iff (reset)
      hcnt_ff <= HCNT_W'(HISTORY_LEN)) else $error("History count out of range.");

   a_flen_range: assert property (@(posedge clock) disable iff (reset)
      flen_ff >= FLEN_MIN) else $error("Front length below its limit.");

endmodule

// File: tb/tb_slope_front_peak_detector_top.sv
`timescale 1ns / 100ps

module tb_slope_front_peak_detector_top;
   import sfpd_pkg::*;

   localparam int SLOPE_W       = 20;
   localparam int SETTLE_CYCLES = 48;
   localparam int LONG_STALL    = 300;
   localparam int CYCLE_LIMIT   = 600000;

   typedef logic signed [SAMPLE_W-1:0]    sample_type;
   typedef logic signed [SLOPE_W-1:0]     slope_type;
   typedef logic signed [FLEN_W-1:0]      flen_type;
   typedef logic [PEAK_INT_W-1:0]         intensity_type;

   typedef struct packed {
      logic          peak;
      intensity_type intensity;
   } peak_result_type;

   class peak_scoreboard;
      logic [CFG_W-1:0] min_slope_reg;
      logic [CFG_W-1:0] ratio_reg;
      sample_type       last_sample;
      sfpd_diff_type    diff_hist [DEF_WINDOW_LEN];
      slope_type        slope_hist [DEF_FRONT_LEN];
      int               diff_idx;
      int               warmup;
      int               slope_idx;
      flen_type         front_run;
      intensity_type    front_max;
      logic             armed;
      intensity_type    peak_log [DEF_HISTORY_LEN];
      int               log_idx;
      peak_result_type  pending [$];
      int unsigned      errors;
      int unsigned      checked;
      int unsigned      peaks;
      int               deepest_run;

      function new();
         min_slope_reg = MIN_SLOPE_RST;
         ratio_reg     = RATIO_RST;
         last_sample   = '0;
         clear_front_windows();
         slope_idx     = 0;
         front_run     = '0;
         front_max     = '0;
         foreach (peak_log[i]) peak_log[i] = '0;
         log_idx       = 0;
         errors        = 0;
         checked       = 0;
         peaks         = 0;
         deepest_run   = 0;
      endfunction

      function void clear_front_windows();
         foreach (diff_hist[i]) diff_hist[i] = '0;
         foreach (slope_hist[i]) slope_hist[i] = '0;
         diff_idx = 0;
         warmup   = 0;
         armed    = 1'b0;
      endfunction

      function void set_reg(input logic idx, input logic [CFG_W-1:0] value);
         if (idx == REG_MIN_SLOPE) begin
            min_slope_reg = value;
         end else begin
            ratio_reg = value;
         end
      endfunction

      function longint history_mean();
         longint total;
         longint count;
         total = 0;
         count = 0;
         foreach (peak_log[i]) begin
            if (peak_log[i] != '0) begin
               total += longint'(peak_log[i]);
               count++;
            end
         end
         return (count == 0) ? 0 : total / count;
      endfunction

      function void note_sample(input logic [SAMPLE_W-1:0] raw);
         sample_type      s;
         sfpd_diff_type   d;
         int              slope_sum;
         int              intensity_sum;
         int              mag;
         peak_result_type r;
         s = raw;
         d = s - last_sample;
         diff_hist[diff_idx] = d;
         last_sample = s;
         diff_idx = (diff_idx + 1) % DEF_WINDOW_LEN;
         r = '0;
         if (warmup < DEF_WINDOW_LEN) begin
            warmup++;
            pending.push_back(r);
            return;
         end
         slope_sum = 0;
         foreach (diff_hist[i]) slope_sum += diff_hist[i];
         slope_hist[slope_idx] = slope_sum;
         slope_idx = (slope_idx + 1) % DEF_FRONT_LEN;
         intensity_sum = 0;
         foreach (slope_hist[i]) intensity_sum += slope_hist[i];

         mag = (slope_sum < 0) ? -slope_sum : slope_sum;
         if (mag >= int'(min_slope_reg)) begin
            if ((slope_sum > 0 && front_run < 0) || (slope_sum < 0 && front_run > 0)) begin
               front_run = '0;
               if (!armed) front_max = '0;
            end else if (slope_sum > 0) begin
               if (front_run < FLEN_MAX) front_run = front_run + 8'sd1;
               if (intensity_sum > int'(front_max)) front_max = intensity_sum;
            end else if (slope_sum < 0) begin
               if (front_run > FLEN_MIN) front_run = front_run - 8'sd1;
            end
         end
         if (int'(front_run) > deepest_run) deepest_run = front_run;
         if (-int'(front_run) > deepest_run) deepest_run = -int'(front_run);

         if (armed && front_run <= -DEF_FRONT_LEN) begin
            peak_log[log_idx] = front_max;
            log_idx = (log_idx + 1) % DEF_HISTORY_LEN;
            clear_front_windows();
            r.peak      = 1'b1;
            r.intensity = front_max;
         end else if (front_run >= DEF_FRONT_LEN) begin
            if (longint'(front_max) * 256 > history_mean() * longint'(ratio_reg)) armed = 1'b1;
         end
         pending.push_back(r);
      endfunction

      task report(input string msg);
         $display("ERROR at %0t: %s", $time, msg);
         errors++;
      endtask

      task check_result(input logic peak, input intensity_type intensity);
         peak_result_type exp_r;
         if (pending.size() == 0) begin
            report($sformatf("result transfer with nothing expected (peak %0b, intensity %0d)",
                             peak, intensity));
         end else begin
            exp_r = pending.pop_front();
            checked++;
            if (exp_r.peak) peaks++;
            if (peak !== exp_r.peak)
               report($sformatf("result %0d: peak %0b, expected %0b", checked, peak, exp_r.peak));
            if (intensity !== exp_r.intensity)
               report($sformatf("result %0d: peak_intensity %0d, expected %0d",
                                checked, intensity, exp_r.intensity));
         end
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [SAMPLE_W-1:0]   req_tdata = '0;    // [15:0] sample
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;         // [21:0] peak_intensity, [23:22] zero
   logic [0:0]            rsp_tuser;         // [0] peak
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   peak_scoreboard sb;
   int unsigned    cycle_count = 0;
   int unsigned    samples_sent = 0;
   int unsigned    csr_writes = 0;
   int unsigned    stall_requests = 0;
   int unsigned    stall_served = 0;
   int unsigned    rx_idle = 0;
   bit             no_idle = 1'b0;
   int             level = 0;

   slope_front_peak_detector_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Run stopped after %0d cycles without finishing.", cycle_count);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tuser[0], rsp_tdata[PEAK_INT_W-1:0]);
      if (stall_served != stall_requests) begin
         stall_served <= stall_requests;
         rx_idle      <= LONG_STALL - 1;
         rsp_tready   <= 1'b0;
      end else if (rx_idle > 0) begin
         rx_idle    <= rx_idle - 1;
         rsp_tready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 5) == 0) begin
         rx_idle    <= $urandom_range(0, 4);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   function automatic int clamp16(input int v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   task automatic send_sample(input int value);
      if (!no_idle && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value[SAMPLE_W-1:0];
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_sample(value[SAMPLE_W-1:0]);
      samples_sent++;
      level = clamp16(value);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic idx, input logic [CFG_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= {{(CSR_DATA_W-CFG_W){1'b0}}, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      sb.set_reg(idx, value);
      csr_writes++;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata !== {{(CSR_DATA_W-CFG_W){1'b0}}, value})
         sb.report($sformatf("register %0d read back 0x%08h, written 0x%04h",
                             idx, csr_prdata, value));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic ramp(input int len, input int step);
      for (int i = 0; i < len; i++) send_sample(clamp16(level + step));
   endtask

   task automatic random_phase(input int unsigned n_items);
      int unsigned target;
      int          kind;
      int          rise;
      int          step;
      target = samples_sent + n_items;
      while (samples_sent < target) begin
         kind = $urandom_range(0, 11);
         if (kind <= 6) begin
            rise = $urandom_range(6, 20);
            ramp(rise, $urandom_range(1, 3000));
            ramp($urandom_range(6, 20), -$urandom_range(1, 3000));
         end else if (kind == 7) begin
            repeat ($urandom_range(4, 12)) send_sample($signed(16'($urandom)));
         end else if (kind == 8) begin
            repeat ($urandom_range(4, 12)) send_sample(clamp16(level + $urandom_range(0, 4) - 2));
         end else if (kind == 9) begin
            ramp($urandom_range(5, 12), $urandom_range(1, 2000));
            ramp($urandom_range(1, 3), -$urandom_range(1, 2000));
         end else if (kind == 10 && $urandom_range(0, 2) == 0) begin
            rise = $urandom_range(130, 150);
            step = $urandom_range(1, 50);
            if (level > 0) step = -step;
            ramp(rise, step);
            ramp(rise, -step);
         end else begin
            send_sample($urandom_range(0, 1) ? 32767 : -32768);
            send_sample(clamp16(level + ($urandom_range(0, 1) ? 1 : -1)));
         end
      end
   endtask

   initial begin
      int directed [] = '{32767, -32768, 0, -1, 1, 32767, -32768, 0,
                          1000, 2000, 3000, 4000, 5000, 6000, 7000, 8000,
                          6000, 4000, 2000, 0, -2000, -4000, -6000, -8000};
      sb = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i]) send_sample(directed[i]);
      random_phase(130);
      settle();

      csr_write(REG_MIN_SLOPE, 16'd0);
      csr_write(REG_RATIO, 16'd0);
      stall_requests <= stall_requests + 1;
      random_phase(120);
      settle();

      csr_write(REG_MIN_SLOPE, 16'hFFFF);
      csr_write(REG_RATIO, 16'hFFFF);
      random_phase(60);
      settle();

      csr_write(REG_MIN_SLOPE, 16'($urandom_range(1, 400)));
      csr_write(REG_RATIO, 16'($urandom_range(128, 512)));
      random_phase(150);
      settle();

      csr_write(REG_MIN_SLOPE, 16'($urandom));
      csr_write(REG_RATIO, 16'($urandom));
      random_phase(60);
      settle();

      csr_write(REG_MIN_SLOPE, MIN_SLOPE_RST);
      csr_write(REG_RATIO, RATIO_RST);
      no_idle = 1'b1;
      random_phase(160);
      settle();

      if (sb.pending.size() != 0)
         sb.report($sformatf("%0d results never arrived", sb.pending.size()));
      $display("Sent %0d samples, checked %0d results with %0d peaks, %0d register writes.",
               samples_sent, sb.checked, sb.peaks, csr_writes);
      $display("Longest front seen: %0d slopes; run took %0d cycles.",
               sb.deepest_run, cycle_count);
      if (sb.errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
